### sv/arpc_pkg.sv
package arpc_pkg;
  localparam int CacheEntries = 16;
  localparam int DeviceBits   = 4;

  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;
  localparam logic [1:0] CMD_TICK   = 2'd3;

  localparam logic [2:0] KIND_INSERT = 3'd0;
  localparam logic [2:0] KIND_LOOKUP = 3'd1;
  localparam logic [2:0] KIND_REQ    = 3'd2;
  localparam logic [2:0] KIND_DROP   = 3'd3;
  localparam logic [2:0] KIND_TICK   = 3'd4;

  localparam logic [1:0] ST_FREE = 2'd0;
  localparam logic [1:0] ST_PEND = 2'd1;
  localparam logic [1:0] ST_RES  = 2'd2;

  localparam logic [15:0] PROTO_IP = 16'h0800;

  localparam logic [1:0] REG_ATTEMPTS = 2'd0;
  localparam logic [1:0] REG_WAIT     = 2'd1;
  localparam logic [1:0] REG_LIFE     = 2'd2;

  localparam int TtlW = 18;
  localparam int RetW = 5;
endpackage

### sv/arpc_if.sv
interface arpc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] protocol;
  logic [31:0] ip_addr;
  logic [47:0] hw_addr;
  logic [3:0]  device_id;
  logic [15:0] tick_delta;
  modport source (output valid, cmd, protocol, ip_addr, hw_addr, device_id, tick_delta,
                  input ready);
  modport sink   (input valid, cmd, protocol, ip_addr, hw_addr, device_id, tick_delta,
                  output ready);
endinterface

interface arpc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic        status;
  logic [3:0]  entry_index;
  logic [1:0]  entry_state;
  logic [31:0] found_ip;
  logic [47:0] found_hw;
  logic [3:0]  found_device;
  logic        last;
  modport source (output valid, kind, status, entry_index, entry_state, found_ip, found_hw,
                  found_device, last, input ready);
  modport sink   (input valid, kind, status, entry_index, entry_state, found_ip, found_hw,
                  found_device, last, output ready);
endinterface

### sv/arp_cache_table.sv
// channel | dir | fields
// in_     | in  | cmd, protocol, ip_addr, hw_addr, device_id, tick_delta
// out_    | out | kind, status, entry_index, entry_state, found_ip, found_hw,
//         |     | found_device, last
// cfg_    | in  | APB: request_attempts, pending_wait_time, resolved_lifetime
// One request at a time; each scan step reads one slot from the memory and,
// for an insert or a tick, may write it back; a tick may give request or drop
// results before its final tick result.
// After reset a clearing pass marks every slot free.
// Each result waits in the output register until taken; the scan holds.
module arp_cache_table #(
  parameter int CACHE_ENTRIES = arpc_pkg::CacheEntries,
  parameter int DEVICE_BITS   = arpc_pkg::DeviceBits
) (
  input  logic        clk,
  input  logic        rst_n,
  arpc_in_if.sink     in_ch,
  arpc_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import arpc_pkg::*;

  localparam int IW = $clog2(CACHE_ENTRIES);
  localparam int CW = IW + 1;
  localparam int MW = 2 + 16 + 32 + 48 + DEVICE_BITS + TtlW + RetW;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;
  localparam logic [2:0] S_WAIT = 3'd5;

  typedef struct packed {
    logic [1:0]             st;
    logic [15:0]            proto;
    logic [31:0]            ip;
    logic [47:0]            hw;
    logic [DEVICE_BITS-1:0] dev;
    logic signed [TtlW-1:0] ttl;
    logic signed [RetW-1:0] ret;
  } slot_t;

  logic [3:0]  attempts_r;
  logic [15:0] wait_r, life_r;
  logic        wr_en;
  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attempts_r <= 4'd3;
      wait_r     <= 16'd1;
      life_r     <= 16'd600;
    end else if (wr_en) begin
      unique case (cfg_paddr[3:2])
        REG_ATTEMPTS: attempts_r <= cfg_pwdata[3:0];
        REG_WAIT:     wait_r     <= cfg_pwdata[15:0];
        REG_LIFE:     life_r     <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_ATTEMPTS: cfg_prdata = {28'd0, attempts_r};
      REG_WAIT:     cfg_prdata = {16'd0, wait_r};
      REG_LIFE:     cfg_prdata = {16'd0, life_r};
      default:      cfg_prdata = 32'd0;
    endcase
  end

  logic [2:0]    state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt, ptr_r, ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]    cmd_r;
  logic [15:0]   proto_r, delta_r;
  logic [31:0]   ip_r;
  logic [47:0]   hw_r;
  logic [DEVICE_BITS-1:0] dev_r;

  logic          we;
  logic [IW-1:0] waddr;
  slot_t         wslot, rslot;
  logic [MW-1:0] rdata;

  arpc_ram #(.Width(MW), .Depth(CACHE_ENTRIES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wslot), .raddr(idx_r), .rdata(rdata)
  );
  assign rslot = slot_t'(rdata);

  logic        ov_r, ov_nxt;
  logic [2:0]  ok_r, ok_nxt;
  logic        os_r, os_nxt, ol_r, ol_nxt;
  logic [3:0]  oi_r, oi_nxt;
  logic [1:0]  ost_r, ost_nxt;
  logic [31:0] oip_r, oip_nxt;
  logic [47:0] ohw_r, ohw_nxt;
  logic [3:0]  odv_r, odv_nxt;

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = ov_r;
  assign out_ch.kind         = ok_r;
  assign out_ch.status       = os_r;
  assign out_ch.entry_index  = oi_r;
  assign out_ch.entry_state  = ost_r;
  assign out_ch.found_ip     = oip_r;
  assign out_ch.found_hw     = ohw_r;
  assign out_ch.found_device = odv_r;
  assign out_ch.last         = ol_r;

  logic signed [TtlW-1:0] ttl_dec;
  logic signed [RetW-1:0] ret_dec;
  logic                   scan_done;
  assign ttl_dec = rslot.ttl - $signed({2'b00, delta_r});
  assign ret_dec = rslot.ret - RetW'(1);
  assign scan_done = (cnt_r == CW'(CACHE_ENTRIES - 1));

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    ptr_nxt = ptr_r;
    cnt_nxt = cnt_r;
    we = 1'b0;
    waddr = idx_r;
    wslot = rslot;
    ov_nxt = ov_r && !out_ch.ready;
    ok_nxt = ok_r; os_nxt = os_r; ol_nxt = ol_r; oi_nxt = oi_r; ost_nxt = ost_r;
    oip_nxt = oip_r; ohw_nxt = ohw_r; odv_nxt = odv_r;
    unique case (state_r)
      S_CLR: begin
        we = 1'b1;
        wslot = '0;
        idx_nxt = idx_r + IW'(1);
        if (idx_r == IW'(CACHE_ENTRIES - 1)) begin
          idx_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          idx_nxt = (in_ch.cmd == CMD_ALLOC || in_ch.cmd == CMD_INSERT) ? ptr_r : '0;
          cnt_nxt = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: state_nxt = S_EVAL;
      S_EVAL: begin
        state_nxt = S_RD;
        idx_nxt = (idx_r == IW'(CACHE_ENTRIES - 1)) ? '0 : idx_r + IW'(1);
        cnt_nxt = cnt_r + CW'(1);
        ok_nxt = '0; os_nxt = 1'b0; ol_nxt = 1'b1; oi_nxt = '0; ost_nxt = ST_FREE;
        oip_nxt = '0; ohw_nxt = '0; odv_nxt = '0;
        case (cmd_r) inside
          CMD_ALLOC, CMD_INSERT: begin
            ok_nxt = KIND_INSERT;
            if (rslot.st == ST_FREE) begin
              we = 1'b1;
              wslot.ip = ip_r;
              wslot.ret = RetW'(attempts_r);
              if (cmd_r == CMD_ALLOC) begin
                wslot.st = ST_PEND; wslot.proto = PROTO_IP; wslot.hw = '0;
                wslot.dev = '0; wslot.ttl = TtlW'(wait_r);
              end else begin
                wslot.st = ST_RES; wslot.proto = proto_r; wslot.hw = hw_r;
                wslot.dev = dev_r; wslot.ttl = TtlW'(life_r);
              end
              ptr_nxt = idx_nxt;
              oi_nxt = 4'(idx_r); ost_nxt = wslot.st; oip_nxt = ip_r;
              ohw_nxt = wslot.hw; odv_nxt = 4'(wslot.dev);
              ov_nxt = 1'b1; state_nxt = S_WAIT;
            end else if (scan_done) begin
              os_nxt = 1'b1; ov_nxt = 1'b1; state_nxt = S_WAIT;
            end
          end
          CMD_LOOKUP: begin
            ok_nxt = KIND_LOOKUP;
            if (rslot.st != ST_FREE && rslot.proto == proto_r && rslot.ip == ip_r) begin
              oi_nxt = 4'(idx_r); ost_nxt = rslot.st; oip_nxt = rslot.ip;
              ohw_nxt = rslot.hw; odv_nxt = 4'(rslot.dev);
              ov_nxt = 1'b1; state_nxt = S_WAIT;
            end else if (scan_done) begin
              os_nxt = 1'b1; ov_nxt = 1'b1; state_nxt = S_WAIT;
            end
          end
          default: begin
            ol_nxt = 1'b0;
            if (rslot.st != ST_FREE) begin
              we = 1'b1;
              wslot.ttl = ttl_dec;
              if (ttl_dec <= 0) begin
                if (rslot.st == ST_RES) begin
                  wslot.st = ST_FREE;
                end else begin
                  wslot.ret = ret_dec;
                  if (ret_dec < 0) begin
                    wslot.st = ST_FREE; ok_nxt = KIND_DROP;
                  end else begin
                    wslot.ttl = TtlW'(wait_r); ok_nxt = KIND_REQ;
                  end
                  oi_nxt = 4'(idx_r); ost_nxt = wslot.st; oip_nxt = rslot.ip;
                  ohw_nxt = rslot.hw; odv_nxt = 4'(rslot.dev);
                  ov_nxt = 1'b1; state_nxt = S_OUT;
                end
              end
            end
            if (scan_done && state_nxt != S_OUT) state_nxt = S_OUT;
            if (scan_done && !ov_nxt) begin
              ok_nxt = KIND_TICK; ol_nxt = 1'b1; ov_nxt = 1'b1; state_nxt = S_WAIT;
            end
          end
        endcase
      end
      S_OUT: begin
        if (!ov_r || out_ch.ready) begin
          if (cnt_r == CW'(CACHE_ENTRIES)) begin
            ok_nxt = KIND_TICK; os_nxt = 1'b0; ol_nxt = 1'b1; oi_nxt = '0;
            ost_nxt = ST_FREE; oip_nxt = '0; ohw_nxt = '0; odv_nxt = '0;
            ov_nxt = 1'b1; state_nxt = S_WAIT;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_WAIT: if (!ov_nxt) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      idx_r   <= '0;
      ptr_r   <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      ptr_r   <= ptr_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid) begin
      cmd_r   <= in_ch.cmd;
      proto_r <= in_ch.protocol;
      ip_r    <= in_ch.ip_addr;
      hw_r    <= in_ch.hw_addr;
      dev_r   <= in_ch.device_id[DEVICE_BITS-1:0];
      delta_r <= in_ch.tick_delta;
    end
    ok_r <= ok_nxt; os_r <= os_nxt; ol_r <= ol_nxt; oi_r <= oi_nxt; ost_r <= ost_nxt;
    oip_r <= oip_nxt; ohw_r <= ohw_nxt; odv_r <= odv_nxt;
  end
endmodule

### sv/arpc_ram.sv
module arpc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### sv/arpc_chk.sv
module arpc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  kind,
  input logic        status,
  input logic        last
);
  import arpc_pkg::*;

  a_nofull_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == KIND_TICK |-> last && !status)
    else $error("tick done must be last and ok");
  a_mid_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (kind == KIND_REQ || kind == KIND_DROP) |-> !last)
    else $error("request/drop result flagged last");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(kind))
    else $error("stalled result changed");
endmodule

bind arp_cache_table arpc_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .kind(out_ch.kind),
  .status(out_ch.status), .last(out_ch.last)
);

### verif/arpc_tb_if.sv
`timescale 1ns / 1ps
package arpc_tb_types;
  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] protocol;
    logic [31:0] ip_addr;
    logic [47:0] hw_addr;
    logic [3:0]  device_id;
    logic [15:0] tick_delta;
  } arp_req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        status;
    logic [3:0]  entry_index;
    logic [1:0]  entry_state;
    logic [31:0] found_ip;
    logic [47:0] found_hw;
    logic [3:0]  found_device;
    logic        last;
  } arp_rsp_t;
endpackage

### verif/tb_arp_cache_table.sv
`timescale 1ns / 1ps
module tb_arp_cache_table;
  import arpc_pkg::*;
  import arpc_tb_types::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [3:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  arpc_in_if in_ch();
  arpc_out_if out_ch();

  arp_cache_table DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // cache shadow
  logic [1:0]  m_state [CacheEntries];
  logic [15:0] m_proto [CacheEntries];
  logic [31:0] m_ip [CacheEntries];
  logic [47:0] m_hw [CacheEntries];
  logic [3:0]  m_dev [CacheEntries];
  int          m_ttl [CacheEntries];
  int          m_retry [CacheEntries];
  int          m_next;
  logic [3:0]  attempts_q;
  logic [15:0] wait_q;
  logic [15:0] life_q;

  arp_req_t pending_reqs[$];
  arp_rsp_t expected_rsps[$];
  int errors = 0;
  bit no_idle = 1'b0;
  int hold_left = 0;
  int tx_gap = 0;
  int rx_gap = 0;

  function automatic arp_rsp_t slot_rsp(logic [2:0] kind, int s, logic lst);
    arp_rsp_t r;
    r = '0;
    r.kind = kind;
    r.last = lst;
    if (s >= 0) begin
      r.entry_index = s[3:0];
      r.entry_state = m_state[s];
      r.found_ip = m_ip[s];
      r.found_hw = m_hw[s];
      r.found_device = m_dev[s];
    end
    return r;
  endfunction

  task automatic predict_cache(input arp_req_t q);
    int s;
    int p;
    arp_rsp_t r;
    s = -1;
    case (q.cmd) inside
      CMD_ALLOC, CMD_INSERT: begin
        p = m_next;
        for (int i = 0; i < CacheEntries; i++) begin
          if (s < 0 && m_state[p] == ST_FREE) s = p;
          p = (p + 1) % CacheEntries;
        end
        if (s < 0) begin
          r = slot_rsp(KIND_INSERT, -1, 1'b1);
          r.status = 1'b1;
          expected_rsps.push_back(r);
        end else begin
          m_ip[s] = q.ip_addr;
          m_retry[s] = int'(attempts_q);
          if (q.cmd == CMD_ALLOC) begin
            m_state[s] = ST_PEND;
            m_proto[s] = PROTO_IP;
            m_hw[s] = '0;
            m_dev[s] = '0;
            m_ttl[s] = int'(wait_q);
          end else begin
            m_state[s] = ST_RES;
            m_proto[s] = q.protocol;
            m_hw[s] = q.hw_addr;
            m_dev[s] = q.device_id;
            m_ttl[s] = int'(life_q);
          end
          m_next = (s + 1) % CacheEntries;
          expected_rsps.push_back(slot_rsp(KIND_INSERT, s, 1'b1));
        end
      end
      CMD_LOOKUP: begin
        for (int i = 0; i < CacheEntries; i++)
          if (s < 0 && m_state[i] != ST_FREE && m_proto[i] == q.protocol &&
              m_ip[i] == q.ip_addr) s = i;
        r = slot_rsp(KIND_LOOKUP, s, 1'b1);
        r.status = (s < 0);
        expected_rsps.push_back(r);
      end
      default: begin
        for (int i = 0; i < CacheEntries; i++) begin
          if (m_state[i] != ST_FREE) begin
            m_ttl[i] -= int'(q.tick_delta);
            if (m_ttl[i] <= 0) begin
              if (m_state[i] == ST_RES) begin
                m_state[i] = ST_FREE;
              end else begin
                m_retry[i] -= 1;
                if (m_retry[i] < 0) begin
                  m_state[i] = ST_FREE;
                  expected_rsps.push_back(slot_rsp(KIND_DROP, i, 1'b0));
                end else begin
                  m_ttl[i] = int'(wait_q);
                  expected_rsps.push_back(slot_rsp(KIND_REQ, i, 1'b0));
                end
              end
            end
          end
        end
        expected_rsps.push_back(slot_rsp(KIND_TICK, -1, 1'b1));
      end
    endcase
  endtask

  // driver
  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = '0;
    in_ch.protocol = '0;
    in_ch.ip_addr = '0;
    in_ch.hw_addr = '0;
    in_ch.device_id = '0;
    in_ch.tick_delta = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    arp_req_t q;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        q = {in_ch.cmd, in_ch.protocol, in_ch.ip_addr, in_ch.hw_addr,
             in_ch.device_id, in_ch.tick_delta};
        predict_cache(q);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_reqs.size() > 0 &&
                     (no_idle || $urandom_range(0, 9) != 0)) begin
          q = pending_reqs.pop_front();
          in_ch.valid <= 1'b1;
          {in_ch.cmd, in_ch.protocol, in_ch.ip_addr, in_ch.hw_addr,
           in_ch.device_id, in_ch.tick_delta} <= q;
        end else begin
          in_ch.valid <= 1'b0;
          if (!no_idle && pending_reqs.size() > 0) tx_gap <= $urandom_range(1, 11);
        end
      end
    end
  end

  // receiver hold-off counter
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // monitor
  always @(posedge clk) begin
    arp_rsp_t got, exp_r;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.kind, out_ch.status, out_ch.entry_index, out_ch.entry_state,
               out_ch.found_ip, out_ch.found_hw, out_ch.found_device, out_ch.last};
        if (expected_rsps.size() == 0) begin
          $error("unexpected result %p", got);
          errors++;
        end else begin
          exp_r = expected_rsps.pop_front();
          if (got.kind !== exp_r.kind) begin
            $error("kind exp %0d got %0d", exp_r.kind, got.kind); errors++;
          end
          if (got.status !== exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, got.status); errors++;
          end
          if (got.entry_index !== exp_r.entry_index) begin
            $error("entry_index exp %0d got %0d", exp_r.entry_index, got.entry_index);
            errors++;
          end
          if (got.entry_state !== exp_r.entry_state) begin
            $error("entry_state exp %0d got %0d", exp_r.entry_state, got.entry_state);
            errors++;
          end
          if (got.found_ip !== exp_r.found_ip) begin
            $error("found_ip exp %h got %h", exp_r.found_ip, got.found_ip); errors++;
          end
          if (got.found_hw !== exp_r.found_hw) begin
            $error("found_hw exp %h got %h", exp_r.found_hw, got.found_hw); errors++;
          end
          if (got.found_device !== exp_r.found_device) begin
            $error("found_device exp %0d got %0d", exp_r.found_device, got.found_device);
            errors++;
          end
          if (got.last !== exp_r.last) begin
            $error("last exp %0d got %0d", exp_r.last, got.last); errors++;
          end
        end
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_ch.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 12) == 0) begin
        rx_gap <= $urandom_range(1, 11);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {16'h0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_ATTEMPTS: attempts_q = val[3:0];
      REG_WAIT: wait_q = val;
      default: life_q = val;
    endcase
  endtask

  task automatic wait_drain();
    while (pending_reqs.size() > 0 || in_ch.valid || expected_rsps.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic arp_req_t mk_req(logic [1:0] c, logic [15:0] pr, logic [31:0] ip,
                                      logic [47:0] hw, logic [3:0] dv, logic [15:0] dt);
    arp_req_t q;
    q = {c, pr, ip, hw, dv, dt};
    return q;
  endfunction

  logic [31:0] used_ips[$];

  function automatic arp_req_t rand_req(int ip_pool);
    arp_req_t q;
    logic [31:0] ip;
    int r;
    r = $urandom_range(0, 99);
    ip = (used_ips.size() > 0 && $urandom_range(0, 2) != 0) ?
         used_ips[$urandom_range(0, used_ips.size() - 1)] : $urandom;
    if (ip_pool > 0) ip = $urandom_range(0, ip_pool);
    q.protocol = ($urandom_range(0, 3) == 0) ? 16'($urandom) : PROTO_IP;
    q.ip_addr = ip;
    q.hw_addr = 48'({$urandom, $urandom});
    q.device_id = 4'($urandom);
    q.tick_delta = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                   16'($urandom_range(0, 8));
    if (r < 30) q.cmd = CMD_ALLOC;
    else if (r < 55) q.cmd = CMD_INSERT;
    else if (r < 80) q.cmd = CMD_LOOKUP;
    else q.cmd = CMD_TICK;
    return q;
  endfunction

  initial begin
    arp_req_t q;
    for (int i = 0; i < CacheEntries; i++) begin
      m_state[i] = ST_FREE; m_proto[i] = '0; m_ip[i] = '0; m_hw[i] = '0;
      m_dev[i] = '0; m_ttl[i] = 0; m_retry[i] = 0;
    end
    m_next = 0; attempts_q = 4'd3; wait_q = 16'd1; life_q = 16'd600;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (CacheEntries + 4) @(posedge clk);

    // directed: defaults, lookup miss, fill to full, expiries
    pending_reqs.push_back(mk_req(CMD_LOOKUP, PROTO_IP, 32'h0, '0, '0, '0));
    pending_reqs.push_back(mk_req(CMD_ALLOC, 16'hFFFF, 32'hFFFF_FFFF, '1, 4'hF, '1));
    pending_reqs.push_back(mk_req(CMD_INSERT, 16'hFFFF, 32'h0, 48'hFFFF_FFFF_FFFF,
                                  4'hF, '0));
    pending_reqs.push_back(mk_req(CMD_INSERT, 16'h0000, 32'hFFFF_FFFF, 48'h0, 4'h0, '1));
    pending_reqs.push_back(mk_req(CMD_LOOKUP, PROTO_IP, 32'hFFFF_FFFF, '0, '0, '0));
    pending_reqs.push_back(mk_req(CMD_LOOKUP, 16'hFFFF, 32'h0, '0, '0, '0));
    pending_reqs.push_back(mk_req(CMD_LOOKUP, 16'h0000, 32'hFFFF_FFFF, '0, '0, '0));
    for (int i = 0; i < 14; i++)
      pending_reqs.push_back(mk_req(CMD_INSERT, 16'h1234, 32'h100 + i,
                                    48'({$urandom, $urandom}), i[3:0], '0));
    pending_reqs.push_back(mk_req(CMD_ALLOC, '0, 32'h55, '0, '0, '0));
    for (int i = 0; i < 4; i++)
      pending_reqs.push_back(mk_req(CMD_TICK, '0, '0, '0, '0, 16'd1));
    pending_reqs.push_back(mk_req(CMD_TICK, '0, '0, '0, '0, 16'hFFFF));
    wait_drain();

    // zero wait time and max attempts
    write_reg(REG_ATTEMPTS, 16'd15);
    write_reg(REG_WAIT, 16'd0);
    write_reg(REG_LIFE, 16'd1);
    for (int i = 0; i < 3; i++)
      pending_reqs.push_back(mk_req(CMD_ALLOC, '0, 32'h200 + i, '0, '0, '0));
    pending_reqs.push_back(mk_req(CMD_INSERT, 16'h0806, 32'h300, '1, 4'h5, '0));
    for (int i = 0; i < 4; i++)
      pending_reqs.push_back(mk_req(CMD_TICK, '0, '0, '0, '0, 16'd0));
    wait_drain();

    // long receiver hold-off: results back up and input stalls
    write_reg(REG_ATTEMPTS, 16'd0);
    write_reg(REG_WAIT, 16'hFFFF);
    write_reg(REG_LIFE, 16'hFFFF);
    hold_left = 300;
    for (int i = 0; i < 20; i++) pending_reqs.push_back(rand_req(0));
    wait (hold_left == 0);
    wait_drain();

    // random phases with varied settings
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_ATTEMPTS, 16'($urandom_range(0, 15)));
      write_reg(REG_WAIT, (ph == 1) ? 16'd1 : 16'($urandom_range(1, 20)));
      write_reg(REG_LIFE, (ph == 2) ? 16'd65535 : 16'($urandom_range(1, 40)));
      for (int i = 0; i < 19; i++) begin
        q = rand_req(ph == 3 ? 7 : 0);
        if (q.cmd == CMD_ALLOC || q.cmd == CMD_INSERT) used_ips.push_back(q.ip_addr);
        pending_reqs.push_back(q);
      end
      if (ph == 3) no_idle = 1'b1;
      wait_drain();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
